### rtl/esde_pkg.sv
// ----------------------------------------------------------------------------
// esde_pkg
// Shared types and constants for the edit-script delta encoder.
// ----------------------------------------------------------------------------
package esde_pkg;

  localparam int unsigned SCRIPT_INDEX_BITS = 16;
  localparam int unsigned MAX_RES          = 5;
  localparam int unsigned RES_CNT_W        = $clog2(MAX_RES + 1);
  localparam logic [7:0]  SAT_MAX          = 8'd255;

  typedef enum logic {
    OP_COMPARE = 1'b0,
    OP_FINISH  = 1'b1
  } op_e;

  typedef logic [SCRIPT_INDEX_BITS-1:0] idx_t;

  typedef struct packed {
    op_e        operation;
    logic [7:0] goal_byte;
    logic [7:0] template_byte;
    logic       dont_care;
    logic       goal_reloc;
    logic       template_reloc;
    logic [7:0] stub_total;
    logic [7:0] stub_number;
  } item_t;

  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  value;
    logic        copy_reloc;
  } res_t;

  // one item's writes, handed from the core to the result buffer
  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] cnt;
    res_t [MAX_RES-1:0]   res;
  } batch_t;

  typedef struct packed {
    logic       in_run;
    logic [7:0] skip_offset;
    logic [7:0] run_count;
    logic [7:0] entry_count;
    idx_t       next_pos;
    idx_t       offset_slot;
    idx_t       count_slot;
    idx_t       group_slot;
  } enc_state_t;

  localparam enc_state_t STATE_RESET = '{
    in_run:      1'b0,
    skip_offset: 8'd0,
    run_count:   8'd0,
    entry_count: 8'd0,
    next_pos:    idx_t'(1),
    offset_slot: '0,
    count_slot:  '0,
    group_slot:  '0
  };

endpackage

### rtl/esde_if.sv
// ----------------------------------------------------------------------------
// esde_if
// Valid/ready channels for byte-pair items and script writes.
// ----------------------------------------------------------------------------
interface esde_in_if;
  import esde_pkg::*;

  logic       valid;
  logic       ready;
  op_e        operation;
  logic [7:0] goal_byte;
  logic [7:0] template_byte;
  logic       dont_care;
  logic       goal_reloc;
  logic       template_reloc;
  logic [7:0] stub_total;
  logic [7:0] stub_number;

  modport source (
    output valid, operation, goal_byte, template_byte, dont_care, goal_reloc,
           template_reloc, stub_total, stub_number,
    input  ready
  );
  modport sink (
    input  valid, operation, goal_byte, template_byte, dont_care, goal_reloc,
           template_reloc, stub_total, stub_number,
    output ready
  );
endinterface

interface esde_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [7:0]  value;
  logic        copy_reloc;
  logic        last;

  modport source (
    output valid, position, value, copy_reloc, last,
    input  ready
  );
  modport sink (
    input  valid, position, value, copy_reloc, last,
    output ready
  );
endinterface

### rtl/esde_core.sv
// ----------------------------------------------------------------------------
// esde_core
// Input register, encoder state and the single-pass write generator.
// ----------------------------------------------------------------------------
module esde_core import esde_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  esde_in_if.sink in_i,
  input  logic   free_i,
  output batch_t batch_o
);

  logic                 in_vld_q;
  item_t                in_q;
  enc_state_t           st_q, st_d;
  res_t [MAX_RES-1:0]   res_d;
  logic [RES_CNT_W-1:0] n_d;
  logic                 change;
  logic                 load;

  assign load       = in_vld_q && free_i;
  assign in_i.ready = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.operation      <= in_i.operation;
      in_q.goal_byte      <= in_i.goal_byte;
      in_q.template_byte  <= in_i.template_byte;
      in_q.dont_care      <= in_i.dont_care;
      in_q.goal_reloc     <= in_i.goal_reloc;
      in_q.template_reloc <= in_i.template_reloc;
      in_q.stub_total     <= in_i.stub_total;
      in_q.stub_number    <= in_i.stub_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (load) begin
      st_q <= st_d;
    end
  end

  assign change = !in_q.dont_care &&
                  (in_q.goal_reloc || in_q.template_reloc ||
                   (in_q.goal_byte != in_q.template_byte));

  // Writes are appended in script order; slots are taken from next_pos.
  always_comb begin
    st_d  = st_q;
    res_d = '0;
    n_d   = '0;
    if (in_q.operation == OP_FINISH) begin
      if (st_q.in_run) begin
        res_d[n_d] = '{16'(st_q.count_slot), st_q.run_count, 1'b0};
        n_d = n_d + 1'b1;
      end
      res_d[n_d] = '{16'(st_q.group_slot), st_q.entry_count, 1'b0};
      n_d = n_d + 1'b1;
      res_d[n_d] = '{16'(st_d.next_pos), 8'd0, 1'b0};
      n_d = n_d + 1'b1;
      st_d.next_pos = st_d.next_pos + 1'b1;
      res_d[n_d] = '{16'(st_d.next_pos), in_q.stub_total, 1'b0};
      n_d = n_d + 1'b1;
      st_d.next_pos = st_d.next_pos + 1'b1;
      res_d[n_d] = '{16'(st_d.next_pos), in_q.stub_number, 1'b0};
      n_d = n_d + 1'b1;
      st_d = STATE_RESET;
    end else if (change) begin
      if (!st_q.in_run) begin
        if (st_q.entry_count == SAT_MAX) begin
          res_d[n_d] = '{16'(st_q.group_slot), SAT_MAX, 1'b0};
          n_d = n_d + 1'b1;
          st_d.entry_count = 8'd0;
          st_d.group_slot  = st_d.next_pos;
          st_d.next_pos    = st_d.next_pos + 1'b1;
        end
        st_d.in_run      = 1'b1;
        st_d.offset_slot = st_d.next_pos;
        st_d.count_slot  = st_d.next_pos + 1'b1;
        st_d.next_pos    = st_d.next_pos + idx_t'(2);
        st_d.entry_count = st_d.entry_count + 1'b1;
        res_d[n_d] = '{16'(st_d.offset_slot), st_q.skip_offset, 1'b0};
        n_d = n_d + 1'b1;
        st_d.run_count = 8'd0;
      end
      // full run: close at 255 and continue in a fresh entry
      if (st_d.run_count == SAT_MAX) begin
        res_d[n_d] = '{16'(st_d.count_slot), SAT_MAX, 1'b0};
        n_d = n_d + 1'b1;
        st_d.offset_slot = st_d.next_pos;
        st_d.count_slot  = st_d.next_pos + 1'b1;
        st_d.next_pos    = st_d.next_pos + idx_t'(2);
        st_d.entry_count = st_d.entry_count + 1'b1;
        res_d[n_d] = '{16'(st_d.offset_slot), 8'd0, 1'b0};
        n_d = n_d + 1'b1;
        st_d.run_count = 8'd0;
      end
      if (in_q.goal_reloc) begin
        res_d[n_d] = '{16'(st_d.next_pos), 8'd0, 1'b1};
      end else begin
        res_d[n_d] = '{16'(st_d.next_pos), in_q.goal_byte, 1'b0};
      end
      n_d = n_d + 1'b1;
      st_d.next_pos  = st_d.next_pos + 1'b1;
      st_d.run_count = st_d.run_count + 1'b1;
    end else if (st_q.in_run) begin
      res_d[n_d] = '{16'(st_q.count_slot), st_q.run_count, 1'b0};
      n_d = n_d + 1'b1;
      st_d.in_run      = 1'b0;
      st_d.skip_offset = 8'd1;
    end else begin
      // long skip: filler entry with offset 255 and count 0
      if (st_q.skip_offset == SAT_MAX) begin
        st_d.offset_slot = st_q.next_pos;
        st_d.count_slot  = st_q.next_pos + 1'b1;
        st_d.next_pos    = st_q.next_pos + idx_t'(2);
        st_d.entry_count = st_q.entry_count + 1'b1;
        res_d[n_d] = '{16'(st_d.offset_slot), SAT_MAX, 1'b0};
        n_d = n_d + 1'b1;
        res_d[n_d] = '{16'(st_d.count_slot), 8'd0, 1'b0};
        n_d = n_d + 1'b1;
        st_d.skip_offset = 8'd0;
      end
      st_d.skip_offset = st_d.skip_offset + 1'b1;
    end
  end

  assign batch_o.load = load;
  assign batch_o.cnt  = n_d;
  assign batch_o.res  = res_d;

endmodule

### rtl/esde_outq.sv
// ----------------------------------------------------------------------------
// esde_outq
// Result buffer: holds one item's writes and drains one beat per cycle while out_o is ready.
// ----------------------------------------------------------------------------
module esde_outq import esde_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  batch_t         batch_i,
  output logic           free_o,
  esde_out_if.source     out_o
);

  logic [RES_CNT_W-1:0] cnt_q;
  res_t [MAX_RES-1:0]   buf_q;
  logic                 pop;

  assign pop    = out_o.valid && out_o.ready;
  // a new batch may land once the last pending beat leaves this cycle
  assign free_o = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (batch_i.load) begin
      cnt_q <= batch_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.load) begin
      buf_q <= batch_i.res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assign out_o.valid      = (cnt_q != '0);
  assign out_o.position   = buf_q[0].position;
  assign out_o.value      = buf_q[0].value;
  assign out_o.copy_reloc = buf_q[0].copy_reloc;
  assign out_o.last       = (cnt_q == RES_CNT_W'(1));

endmodule

### rtl/edit_script_delta_encoder_unit.sv
// ----------------------------------------------------------------------------
// edit_script_delta_encoder_unit
// Patch-script encoder: byte pairs in, script byte writes out.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  in_i    | in  | operation, goal/template byte and flags, stub fields
//  out_o   | out | position, value, copy_reloc, last
//
//  An accepted item is registered; its 0 to 5 writes are then computed and
//  loaded into the result buffer once it is free. The buffer sends one beat
//  per cycle while out_o is ready. Unstalled, items with at most one write
//  sustain one item per cycle; more writes hold input until all are sent.
//  Reset puts the encoder at the start of a new script (next position 1).
//  Output stalls back up through the buffer into the input register.
module edit_script_delta_encoder_unit import esde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  esde_in_if.sink     in_i,
  esde_out_if.source  out_o
);

  batch_t batch;
  logic   free;

  esde_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .free_i  (free),
    .batch_o (batch)
  );

  esde_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .batch_i (batch),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

### dv/esde_script_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esde_script_checker
// Watches the byte-pair and script-write channels of the delta encoder,
// rebuilds the patch script from every accepted pair and compares each
// write beat, in order, with the predicted one.
// ----------------------------------------------------------------------------
module esde_script_checker import esde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  esde_in_if   in_mon,
  esde_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   writes_o
);

  typedef struct packed {
    logic [15:0] position;
    logic [7:0]  value;
    logic        copy_reloc;
    logic        last;
  } script_write_t;

  // encoder state, tracked alongside the block
  logic       run_open;
  logic [7:0] skip_len;
  logic [7:0] run_len;
  logic [7:0] entries_in_group;
  idx_t       write_ptr;
  idx_t       offset_pos;
  idx_t       count_pos;
  idx_t       group_pos;

  script_write_t expected_writes[$];
  script_write_t item_writes[$];
  script_write_t want;
  item_t         pair_beat;
  int            fail_count = 0;
  int            writes_seen = 0;

  assign fail_count_o = fail_count;
  assign writes_o     = writes_seen;

  function automatic void reset_script();
    run_open         = 1'b0;
    skip_len         = '0;
    run_len          = '0;
    entries_in_group = '0;
    write_ptr        = idx_t'(1);  // slot 0 holds the first group count
    offset_pos       = '0;
    count_pos        = '0;
    group_pos        = '0;
  endfunction

  function automatic idx_t claim_slot();
    idx_t slot;
    slot      = write_ptr;
    write_ptr = write_ptr + idx_t'(1);
    return slot;
  endfunction

  function automatic void add_write(idx_t pos, logic [7:0] val, logic rel);
    script_write_t w;
    w.position   = 16'(pos);
    w.value      = val;
    w.copy_reloc = rel;
    w.last       = 1'b0;
    item_writes.push_back(w);
  endfunction

  function automatic void open_entry();
    offset_pos       = claim_slot();
    count_pos        = claim_slot();
    entries_in_group = entries_in_group + 8'd1;  // wraps, no full-group check here
  endfunction

  function automatic void encode_item(item_t it);
    logic          differs;
    script_write_t tail;
    item_writes.delete();
    if (it.operation == OP_FINISH) begin
      if (run_open) add_write(count_pos, run_len, 1'b0);
      add_write(group_pos, entries_in_group, 1'b0);
      add_write(claim_slot(), 8'd0, 1'b0);
      add_write(claim_slot(), it.stub_total, 1'b0);
      add_write(claim_slot(), it.stub_number, 1'b0);
      reset_script();
    end else begin
      differs = !it.dont_care &&
                (it.goal_reloc || it.template_reloc || it.goal_byte != it.template_byte);
      if (differs) begin
        if (!run_open) begin
          if (entries_in_group == SAT_MAX) begin
            add_write(group_pos, SAT_MAX, 1'b0);
            entries_in_group = '0;
            group_pos        = claim_slot();
          end
          run_open = 1'b1;
          open_entry();
          add_write(offset_pos, skip_len, 1'b0);
          run_len = '0;
        end
        if (run_len == SAT_MAX) begin
          add_write(count_pos, SAT_MAX, 1'b0);
          open_entry();
          add_write(offset_pos, 8'd0, 1'b0);
          run_len = '0;
        end
        if (it.goal_reloc) add_write(claim_slot(), 8'd0, 1'b1);
        else               add_write(claim_slot(), it.goal_byte, 1'b0);
        run_len = run_len + 8'd1;
      end else if (run_open) begin
        add_write(count_pos, run_len, 1'b0);
        run_open = 1'b0;
        skip_len = 8'd1;
      end else begin
        // long skip: filler entry with count 0
        if (skip_len == SAT_MAX) begin
          open_entry();
          add_write(offset_pos, SAT_MAX, 1'b0);
          add_write(count_pos, 8'd0, 1'b0);
          skip_len = '0;
        end
        skip_len = skip_len + 8'd1;
      end
    end
    if (item_writes.size() > 0) begin
      tail      = item_writes.pop_back();
      tail.last = 1'b1;
      item_writes.push_back(tail);
    end
    foreach (item_writes[k]) expected_writes.push_back(item_writes[k]);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] script write error: %s", $time, what);
  endtask

  initial reset_script();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_script();
      expected_writes.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        pair_beat.operation      = in_mon.operation;
        pair_beat.goal_byte      = in_mon.goal_byte;
        pair_beat.template_byte  = in_mon.template_byte;
        pair_beat.dont_care      = in_mon.dont_care;
        pair_beat.goal_reloc     = in_mon.goal_reloc;
        pair_beat.template_reloc = in_mon.template_reloc;
        pair_beat.stub_total     = in_mon.stub_total;
        pair_beat.stub_number    = in_mon.stub_number;
        encode_item(pair_beat);
      end
      if (out_mon.valid && out_mon.ready) begin
        writes_seen++;
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected beat pos=%0d value=%0d",
                                    out_mon.position, out_mon.value));
        end else begin
          want = expected_writes.pop_front();
          if (out_mon.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_mon.position, want.position));
          if (out_mon.value !== want.value)
            report_mismatch($sformatf("value %0d at pos %0d, expected %0d",
                                      out_mon.value, want.position, want.value));
          if (out_mon.copy_reloc !== want.copy_reloc)
            report_mismatch($sformatf("copy_reloc %b at pos %0d, expected %b",
                                      out_mon.copy_reloc, want.position, want.copy_reloc));
          if (out_mon.last !== want.last)
            report_mismatch($sformatf("last %b at pos %0d, expected %b",
                                      out_mon.last, want.position, want.last));
        end
      end
    end
    pending_o <= expected_writes.size();
  end

endmodule

### dv/edit_script_delta_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_script_delta_encoder_unit_tb
// Drives byte pairs and finish items into the delta encoder: a short
// directed script, then random scripts of runs, skips, noise and early
// finishes, with random stalls on both channels. The checker beside the
// block predicts and compares the writes.
// ----------------------------------------------------------------------------
module edit_script_delta_encoder_unit_tb;
  import esde_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 16;
  localparam int CHUNK_ITEMS  = 40;
  localparam int IDLE_CHUNKS  = 5;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on = 1'b0;
  int   items_sent = 0;
  int   finishes_sent = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending_writes;
  int   writes_checked;

  esde_in_if  in_ch ();
  esde_out_if out_ch ();

  edit_script_delta_encoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  esde_script_checker u_script_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_writes),
    .writes_o     (writes_checked)
  );

  always #6 clk_i = ~clk_i;

  // output back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat for %0d cycles, pending writes %0d", quiet_cycles, pending_writes);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t make_item(op_e op, logic [7:0] goal, logic [7:0] tmpl,
                                      logic dc, logic grel, logic trel,
                                      logic [7:0] st, logic [7:0] sn);
    item_t it;
    it.operation      = op;
    it.goal_byte      = goal;
    it.template_byte  = tmpl;
    it.dont_care      = dc;
    it.goal_reloc     = grel;
    it.template_reloc = trel;
    it.stub_total     = st;
    it.stub_number    = sn;
    return it;
  endfunction

  // random pair that either must or must not land in the script
  function automatic item_t pair_item(bit differ);
    item_t it;
    it = make_item(OP_COMPARE, 8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0,
                   8'($urandom), 8'($urandom));
    if (differ) begin
      case ($urandom_range(0, 3))
        0: begin
          it.goal_reloc     = 1'b1;
          it.template_reloc = 1'($urandom);
        end
        1: it.template_reloc = 1'b1;
        default: it.goal_byte = it.template_byte ^ 8'($urandom_range(1, 255));
      endcase
    end else if ($urandom_range(0, 3) == 0) begin
      it.dont_care      = 1'b1;
      it.goal_reloc     = 1'($urandom);
      it.template_reloc = 1'($urandom);
    end else begin
      it.template_byte = it.goal_byte;
    end
    return it;
  endfunction

  function automatic item_t finish_item();
    return make_item(OP_FINISH, 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_item(input item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= it.operation;
    in_ch.goal_byte      <= it.goal_byte;
    in_ch.template_byte  <= it.template_byte;
    in_ch.dont_care      <= it.dont_care;
    in_ch.goal_reloc     <= it.goal_reloc;
    in_ch.template_reloc <= it.template_reloc;
    in_ch.stub_total     <= it.stub_total;
    in_ch.stub_number    <= it.stub_number;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (it.operation == OP_FINISH) finishes_sent++;
  endtask

  // mostly runs and skips of random length, some noise and early finishes
  task automatic random_scripts(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0: begin
          send_item(finish_item());
          sent++;
        end
        1, 2: begin
          send_item(make_item(OP_COMPARE, 8'($urandom), 8'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
          sent++;
        end
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
          repeat (len) send_item(pair_item(1'b1));
          sent += len;
          len = $urandom_range(1, 6);
          repeat (len) send_item(pair_item(1'b0));
          sent += len;
        end
      endcase
    end
  endtask

  initial begin
    rst_ni               <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_COMPARE;
    in_ch.goal_byte      <= '0;
    in_ch.template_byte  <= '0;
    in_ch.dont_care      <= 1'b0;
    in_ch.goal_reloc     <= 1'b0;
    in_ch.template_reloc <= 1'b0;
    in_ch.stub_total     <= '0;
    in_ch.stub_number    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, relocation, don't-care, finish variants
    send_item(make_item(OP_COMPARE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF));
    send_item(make_item(OP_COMPARE, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'h5A, 8'h5A, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'hA5, 8'hA5, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'h12, 8'h34, 1'b1, 1'b1, 1'b1, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'h01, 8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_FINISH,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'hFF, 8'h00));
    send_item(make_item(OP_FINISH,  8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 8'hFF));
    send_item(make_item(OP_COMPARE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_COMPARE, 8'h3C, 8'hC3, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00));
    send_item(make_item(OP_FINISH,  8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h55, 8'hAA));

    // random scripts, idling switched per chunk, then a clean stretch
    repeat (IDLE_CHUNKS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_scripts(CHUNK_ITEMS);
    end
    idle_on = 1'b0;
    random_scripts(CHUNK_ITEMS);
    send_item(finish_item());
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending_writes != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d finishes) in directed and random scripts with stalls",
             items_sent, finishes_sent);
    $display("Checked %0d script writes, %0d errors", writes_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
